// File: rtl/asc_pkg.sv
// shared types, constants and the arctangent table for the ackermann steering block
// no dependencies; used by every module of the block
package asc_pkg;

    localparam int VW           = 54;   // cordic vector and product working width
    localparam int ZW           = 34;   // cordic angle accumulator, 2^-30 rad units
    localparam int AW           = 16;   // q2.13 angle width
    localparam int MAW          = 17;   // multiplier operand a
    localparam int MBW          = 32;   // multiplier operand b
    localparam int PW           = MAW + MBW;
    localparam int PVW          = 44;   // speed numerator product v*num
    localparam int DMW          = 63;   // dividend magnitude
    localparam int DDW          = 43;   // divisor width
    localparam int QW           = 32;   // quotient width
    localparam int TAB_LEN      = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic [13:0] ANGLE_MAX_Q13 = 14'd12867;
    localparam logic signed [VW-1:0] NORM_LIM = VW'(134217728);

    localparam logic OP_CMD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        CFG_WHEEL_BASE   = 3'd0,
        CFG_WHEEL_TRACK  = 3'd1,
        CFG_WHEEL_RADIUS = 3'd2,
        CFG_MAX_ANGLE    = 3'd3,
        CFG_TIMEOUT      = 3'd4
    } t_cfg_idx;

    typedef logic signed [VW-1:0] t_vec;
    typedef logic signed [AW-1:0] t_ang;

    typedef struct packed {
        logic start;
        logic vec;      // 1 vectoring (atan2), 0 rotation
    } t_cor_req;

    typedef struct packed {
        logic start;
        logic neg;
    } t_div_req;

    function automatic logic [29:0] atan_tab(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/ackermann_steering_command.sv
// ackermann steering command: drive commands become front angles and rear wheel speeds
// sequencer with one shared multiplier; uses asc_pkg, asc_cordic and asc_div
//
//  channel   dir  handshake                      payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata: linear_velocity, steer_req
//                                                 tuser: op
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata: rear_right, rear_left,
//                                                 front_left, front_right; tuser: timed_out
//  cfg       in   i_cfg_we                        i_cfg_idx, i_cfg_data
//
// a publish tick loads the output register
// a turning command runs the cordic unit five times and the multiply states LM1 to LM4 and FM1 to FM4,
// then two speed passes, each shifting its operands right in the normalize state until they fit
// a straight command takes only the two speed passes
// s_axis is not ready while a command runs or while an unconsumed item blocks m_axis
// reset is synchronous active low; it clears the held values and loads register defaults
module ackermann_steering_command #(
    parameter int CORDIC_STEPS = asc_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // linear_velocity[15:0], steer_req[31:16]
    input  logic [0:0]  i_s_axis_tuser,   // op[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [95:0] o_m_axis_tdata,   // rear_right[31:0], rear_left[63:32],
                                          // front_left[79:64], front_right[95:80]
    output logic [0:0]  o_m_axis_tuser,   // timed_out[0]
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import asc_pkg::*;

    typedef enum logic [24:0] {
        S_IDLE   = 25'h0000001,
        S_ROT1   = 25'h0000002,
        S_ROT1_W = 25'h0000004,
        S_LM1    = 25'h0000008,
        S_LM2    = 25'h0000010,
        S_LM3    = 25'h0000020,
        S_LM4    = 25'h0000040,
        S_ATL    = 25'h0000080,
        S_ATL_W  = 25'h0000100,
        S_ROT2   = 25'h0000200,
        S_ROT2_W = 25'h0000400,
        S_FM1    = 25'h0000800,
        S_FM2    = 25'h0001000,
        S_FM3    = 25'h0002000,
        S_FM4    = 25'h0004000,
        S_AFL    = 25'h0008000,
        S_AFL_W  = 25'h0010000,
        S_AFR    = 25'h0020000,
        S_AFR_W  = 25'h0040000,
        S_SP_LD  = 25'h0080000,
        S_NORM   = 25'h0100000,
        S_SM1    = 25'h0200000,
        S_SM2    = 25'h0400000,
        S_SM3    = 25'h0800000,
        S_DIV_W  = 25'h1000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [15:0] r_wheel_base, r_wheel_track, r_wheel_radius;
    logic [13:0] r_max_angle;
    logic [7:0]  r_timeout;

    // held outputs and tick counter
    logic signed [QW-1:0] r_held_rr, r_held_rl;
    t_ang                 r_held_fl, r_held_fr;
    logic [7:0]           r_ticks;

    // output register
    logic        r_out_valid;
    logic [95:0] r_out_data;
    logic        r_out_flag;

    // working registers
    t_ang                  r_v, r_a, r_ang, r_fl, r_fr;
    logic                  r_straight, r_side;
    logic signed [MBW-1:0] r_cc, r_ss;
    logic signed [PW-1:0]  r_prod;
    t_vec                  r_vx, r_vy, r_two, r_ts, r_num, r_den;
    logic signed [PVW-1:0] r_pv;
    logic signed [QW-1:0]  r_rr;

    logic                  w_in_acc, w_tick, w_cmd, w_flag;
    logic [15:0]           w_l, w_r;
    logic [13:0]           w_amax;
    logic signed [MAW-1:0] w_ma;
    logic signed [MBW-1:0] w_mb;
    t_cor_req              w_cor_req;
    t_vec                  w_cor_x, w_cor_y, w_cor_ox, w_cor_oy;
    t_ang                  w_cor_ang, w_cor_oang, w_lim, w_nlim;
    logic                  w_cor_done;
    t_div_req              w_div_req;
    logic [DMW-1:0]        w_div_mag;
    logic [PVW-1:0]        w_pv_abs;
    logic                  w_div_done;
    logic signed [QW-1:0]  w_div_q;
    logic signed [27:0]    w_num28, w_den28;
    logic                  w_big;

    assign w_l    = (r_wheel_base == '0) ? 16'd1 : r_wheel_base;
    assign w_r    = (r_wheel_radius == '0) ? 16'd1 : r_wheel_radius;
    assign w_amax = (r_max_angle > ANGLE_MAX_Q13) ? ANGLE_MAX_Q13 : r_max_angle;

    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_tick   = w_in_acc && (i_s_axis_tuser[0] == OP_TICK);
    assign w_cmd    = w_in_acc && (i_s_axis_tuser[0] == OP_CMD);
    assign w_flag   = r_ticks >= r_timeout;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_base   <= 16'd12288;
            r_wheel_track  <= 16'd7373;
            r_wheel_radius <= 16'd1556;
            r_max_angle    <= 14'd4915;
            r_timeout      <= 8'd2;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_WHEEL_BASE:   r_wheel_base   <= i_cfg_data;
                CFG_WHEEL_TRACK:  r_wheel_track  <= i_cfg_data;
                CFG_WHEEL_RADIUS: r_wheel_radius <= i_cfg_data;
                CFG_MAX_ANGLE:    r_max_angle    <= i_cfg_data[13:0];
                CFG_TIMEOUT:      r_timeout      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // shared multiplier operand select
    always_comb begin
        w_ma = signed'({1'b0, w_l});
        w_mb = r_ss;
        case (r_state)
            S_LM1:   begin w_ma = signed'({1'b0, w_l});           w_mb = r_ss; end
            S_LM2:   begin w_ma = signed'({1'b0, w_l});           w_mb = r_cc; end
            S_LM3:   begin w_ma = signed'({1'b0, r_wheel_track}); w_mb = r_ss; end
            S_FM1:   begin w_ma = signed'({1'b0, w_l});           w_mb = r_cc; end
            S_FM2:   begin w_ma = signed'({1'b0, r_wheel_track}); w_mb = r_ss; end
            S_FM3:   begin w_ma = signed'({1'b0, w_l});           w_mb = r_ss; end
            S_SM1:   begin w_ma = MAW'(r_v);                      w_mb = MBW'(w_num28); end
            S_SM2:   begin w_ma = signed'({1'b0, w_r});           w_mb = MBW'(w_den28); end
            default: ;
        endcase
    end

    assign w_num28 = r_num[27:0];
    assign w_den28 = (r_den < 1) ? 28'sd1 : r_den[27:0];
    assign w_big   = (r_num >= NORM_LIM) || (r_num <= -NORM_LIM) || (r_den >= NORM_LIM);

    // cordic requests
    always_comb begin
        w_cor_req = '{start: 1'b0, vec: 1'b0};
        w_cor_x   = r_vx;
        w_cor_y   = r_vy;
        w_cor_ang = r_ang;
        case (r_state)
            S_ROT1: begin
                w_cor_req = '{start: 1'b1, vec: 1'b0};
                w_cor_ang = AW'(w_amax);
            end
            S_ATL:  w_cor_req = '{start: 1'b1, vec: 1'b1};
            S_ROT2: w_cor_req = '{start: 1'b1, vec: 1'b0};
            S_AFL: begin
                w_cor_req = '{start: 1'b1, vec: 1'b1};
                w_cor_x   = r_two - r_ts;
            end
            S_AFR: begin
                w_cor_req = '{start: 1'b1, vec: 1'b1};
                w_cor_x   = r_two + r_ts;
            end
            default: ;
        endcase
    end

    asc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_cor_req),
        .i_x     (w_cor_x),
        .i_y     (w_cor_y),
        .i_ang   (w_cor_ang),
        .o_done  (w_cor_done),
        .o_x     (w_cor_ox),
        .o_y     (w_cor_oy),
        .o_ang   (w_cor_oang)
    );

    // speed dividend magnitude is |v*num| * 2^20
    assign w_pv_abs  = r_pv[PVW-1] ? PVW'(-r_pv) : PVW'(r_pv);
    assign w_div_mag = {w_pv_abs[DMW-21:0], 20'b0};
    assign w_div_req = '{start: (r_state == S_SM3), neg: r_pv[PVW-1]};

    asc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .i_mag   (w_div_mag),
        .i_den   (r_prod[DDW-1:0]),
        .o_done  (w_div_done),
        .o_q     (w_div_q)
    );

    // steering limit, negative limit treated as zero
    assign w_lim  = w_cor_oang[AW-1] ? '0 : w_cor_oang;
    assign w_nlim = -w_lim;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_cmd) n_state = (i_s_axis_tdata[31:16] == '0) ? S_SP_LD : S_ROT1;
            S_ROT1:   n_state = S_ROT1_W;
            S_ROT1_W: if (w_cor_done) n_state = S_LM1;
            S_LM1:    n_state = S_LM2;
            S_LM2:    n_state = S_LM3;
            S_LM3:    n_state = S_LM4;
            S_LM4:    n_state = S_ATL;
            S_ATL:    n_state = S_ATL_W;
            S_ATL_W:  if (w_cor_done) n_state = S_ROT2;
            S_ROT2:   n_state = S_ROT2_W;
            S_ROT2_W: if (w_cor_done) n_state = S_FM1;
            S_FM1:    n_state = S_FM2;
            S_FM2:    n_state = S_FM3;
            S_FM3:    n_state = S_FM4;
            S_FM4:    n_state = S_AFL;
            S_AFL:    n_state = S_AFL_W;
            S_AFL_W:  if (w_cor_done) n_state = S_AFR;
            S_AFR:    n_state = S_AFR_W;
            S_AFR_W:  if (w_cor_done) n_state = S_SP_LD;
            S_SP_LD:  n_state = S_NORM;
            S_NORM:   if (!w_big) n_state = S_SM1;
            S_SM1:    n_state = S_SM2;
            S_SM2:    n_state = S_SM3;
            S_SM3:    n_state = S_DIV_W;
            S_DIV_W:  if (w_div_done) n_state = r_side ? S_IDLE : S_SP_LD;
            default:  n_state = S_IDLE;
        endcase
    end

    // control and held state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_ticks     <= '0;
            r_held_rr   <= '0;
            r_held_rl   <= '0;
            r_held_fl   <= '0;
            r_held_fr   <= '0;
            r_side      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_tick) begin
                r_out_valid <= 1'b1;
                if (w_flag) begin
                    r_held_rr <= '0;
                    r_held_rl <= '0;
                    r_held_fl <= '0;
                    r_held_fr <= '0;
                end else begin
                    r_ticks <= 8'(r_ticks + 8'd1);
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_cmd) begin
                r_ticks <= '0;
                r_side  <= 1'b0;
            end
            if ((r_state == S_DIV_W) && w_div_done) begin
                if (!r_side) begin
                    r_side <= 1'b1;
                end else begin
                    r_held_rr <= r_rr;
                    r_held_rl <= w_div_q;
                    r_held_fl <= r_straight ? '0 : r_fl;
                    r_held_fr <= r_straight ? '0 : r_fr;
                end
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_out_flag <= w_flag;
            if (w_flag) begin
                r_out_data <= '0;
            end else begin
                r_out_data <= {r_held_fr, r_held_fl, r_held_rl, r_held_rr};
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (w_cmd) begin
            r_v        <= i_s_axis_tdata[15:0];
            r_a        <= i_s_axis_tdata[31:16];
            r_straight <= (i_s_axis_tdata[31:16] == '0);
        end
        case (r_state)
            S_ROT1_W: if (w_cor_done) begin
                r_cc <= w_cor_ox[MBW-1:0];
                r_ss <= w_cor_oy[MBW-1:0];
            end
            S_LM2:   r_vy <= VW'(r_prod) <<< 1;
            S_LM3:   r_vx <= VW'(r_prod) <<< 1;
            S_LM4:   r_vx <= r_vx + VW'(r_prod);
            S_ATL_W: if (w_cor_done) begin
                if (r_a > w_lim) begin
                    r_ang <= w_lim;
                end else if (r_a < w_nlim) begin
                    r_ang <= w_nlim;
                end else begin
                    r_ang <= r_a;
                end
            end
            S_ROT2_W: if (w_cor_done) begin
                // near-vertical angle: cosine held at one lsb
                r_cc <= (w_cor_ox < 1) ? MBW'(1) : w_cor_ox[MBW-1:0];
                r_ss <= w_cor_oy[MBW-1:0];
            end
            S_FM2:   r_two <= VW'(r_prod) <<< 1;
            S_FM3:   r_ts  <= VW'(r_prod);
            S_FM4:   r_vy  <= VW'(r_prod) <<< 1;
            S_AFL_W: if (w_cor_done) r_fl <= w_cor_oang;
            S_AFR_W: if (w_cor_done) r_fr <= w_cor_oang;
            S_SP_LD: begin
                if (r_straight) begin
                    r_num <= VW'(1);
                    r_den <= VW'(1);
                end else begin
                    r_num <= r_side ? (r_two + r_ts) : (r_two - r_ts);
                    r_den <= r_two;
                end
            end
            S_NORM: if (w_big) begin
                r_num <= r_num >>> 1;
                r_den <= r_den >>> 1;
            end
            S_SM2:   r_pv <= r_prod[PVW-1:0];
            S_DIV_W: if (w_div_done && !r_side) r_rr <= w_div_q;
            default: ;
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_flag;

endmodule

// File: rtl/asc_cordic.sv
// shared iterative cordic: rotation (cos/sin of a q2.13 angle) and vectoring (atan2)
// one micro-rotation per cycle; depends on asc_pkg
module asc_cordic #(
    parameter int STEPS = asc_pkg::CORDIC_STEPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  asc_pkg::t_cor_req i_req,
    input  asc_pkg::t_vec    i_x,
    input  asc_pkg::t_vec    i_y,
    input  asc_pkg::t_ang    i_ang,
    output logic             o_done,
    output asc_pkg::t_vec    o_x,
    output asc_pkg::t_vec    o_y,
    output asc_pkg::t_ang    o_ang
);
    import asc_pkg::*;

    localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [IW-1:0] LAST = IW'(STEPS - 1);

    logic                 r_busy, r_done, r_vec;
    logic [IW-1:0]        r_i;
    t_vec                 r_x, r_y;
    logic signed [ZW-1:0] r_z;

    t_vec                 w_dx, w_dy;
    logic signed [ZW-1:0] w_tab, w_z0;
    logic signed [ZW:0]   w_rnd;
    logic                 w_up;

    assign w_dx  = r_y >>> r_i;
    assign w_dy  = r_x >>> r_i;
    assign w_tab = ZW'(atan_tab(5'(r_i)));
    assign w_z0  = {{(ZW-33){i_ang[AW-1]}}, i_ang, 17'b0};
    // vectoring drives y toward zero, rotation drives z toward zero
    assign w_up  = r_vec ? (r_y > 0) : (r_z >= 0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (i_req.vec && (i_y == 0)) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy && (r_i == LAST)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_vec <= i_req.vec;
            r_i   <= '0;
            if (i_req.vec) begin
                r_x <= (i_x < 0) ? '0 : i_x;
                r_y <= i_y;
                r_z <= '0;
            end else begin
                r_x <= VW'(64'sd1073741824);
                r_y <= '0;
                r_z <= w_z0;
            end
        end else if (r_busy) begin
            r_i <= r_i + 1'b1;
            if (r_vec) begin
                if (w_up) begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_tab;
                end else begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_tab;
                end
            end else begin
                if (w_up) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_tab;
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_tab;
                end
            end
        end
    end

    // round 2^-30 rad to q2.13, half up
    assign w_rnd  = {r_z[ZW-1], r_z} + (ZW+1)'(65536);
    assign o_ang  = w_rnd[17 +: AW];
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_done = r_done;

endmodule

// File: rtl/asc_div.sv
// iterative restoring divider for the wheel speeds, one quotient bit per cycle
// saturates the signed 32 bit result; depends on asc_pkg
module asc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  asc_pkg::t_div_req  i_req,
    input  logic [asc_pkg::DMW-1:0] i_mag,
    input  logic [asc_pkg::DDW-1:0] i_den,
    output logic               o_done,
    output logic signed [asc_pkg::QW-1:0] o_q
);
    import asc_pkg::*;

    localparam int CW = $clog2(QW);
    localparam logic [CW-1:0] LAST = CW'(QW - 1);
    localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

    logic           r_busy, r_done;
    logic [CW-1:0]  r_cnt;
    logic [DDW-1:0] r_rem, r_den;
    logic [QW-1:0]  r_low, r_q;
    logic           r_ovf, r_neg;

    logic [DDW:0]   w_rem2;
    logic           w_ge;
    logic [DDW:0]   w_sub;

    assign w_rem2 = {r_rem, r_low[QW-1]};
    assign w_ge   = w_rem2 >= {1'b0, r_den};
    assign w_sub  = w_rem2 - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                // quotient of 2^32 or more saturates without iterating
                if (DDW'(i_mag[DMW-1:QW]) >= i_den) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy && (r_cnt == LAST)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= '0;
            r_rem <= DDW'(i_mag[DMW-1:QW]);
            r_low <= i_mag[QW-1:0];
            r_den <= i_den;
            r_neg <= i_req.neg;
            r_ovf <= DDW'(i_mag[DMW-1:QW]) >= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= w_ge ? w_sub[DDW-1:0] : w_rem2[DDW-1:0];
            r_low <= {r_low[QW-2:0], 1'b0};
            r_q   <= {r_q[QW-2:0], w_ge};
        end
    end

    always_comb begin
        if (r_ovf) begin
            o_q = r_neg ? Q_MIN : Q_MAX;
        end else if (!r_neg) begin
            o_q = r_q[QW-1] ? Q_MAX : $signed(r_q);
        end else if (r_q > {1'b1, {(QW-1){1'b0}}}) begin
            o_q = Q_MIN;
        end else begin
            o_q = $signed(-r_q);
        end
    end

    assign o_done = r_done;

endmodule
